// File: sv/mrlt_pkg.sv
// shared constants, field layout and controller/datapath interface types
package mrlt_pkg;

    // default string depth
    localparam int MAX_LEN_DEF = 1024;

    // field widths
    localparam int MODE_W = 1;
    localparam int SEL_W  = 1;
    localparam int POS_W  = 10;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 11;
    localparam int RUN_W  = 11;

    // length register value after reset
    localparam int LEN_RESET = 1024;

    // stream word layout
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;
    localparam int POS_LSB  = 0;
    localparam int CHAR_LSB = POS_LSB + POS_W;
    localparam int MODE_BIT = 0;
    localparam int SEL_BIT  = MODE_BIT + MODE_W;

    // mode codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic clr;        // one step of the clearing sweep
        logic load;       // capture the input word
        logic str_rw;     // write own string, read both strings
        logic leaf_set;   // write the leaf match bit
        logic sib_rd;     // read the sibling node
        logic par_write;  // merge children, write parent, climb
        logic leaf_rd;    // read the leaf for a query
        logic acc_one;    // leaf matched, run starts at one
        logic climb;      // move to the parent node
        logic acc_sib;    // add the sibling leading run
        logic out_load;   // load the result register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic is_query;
        logic in_range;
        logic root;
        logic node_right;
        logic leaf_zero;
        logic sib_full;
        logic out_free;
    } t_sts;

endpackage

// File: sv/mrlt_ctrl.sv
// sequencer for the clearing sweep, tree updates and tree queries
module mrlt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_valid,
    output logic            o_s_ready,
    input  mrlt_pkg::t_sts  i_sts,
    output mrlt_pkg::t_cmd  o_cmd
);
    import mrlt_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_DECODE = 12'b0000_0000_0100,
        S_W_RD   = 12'b0000_0000_1000,
        S_W_LEAF = 12'b0000_0001_0000,
        S_W_UP   = 12'b0000_0010_0000,
        S_W_PAR  = 12'b0000_0100_0000,
        S_Q_LEAF = 12'b0000_1000_0000,
        S_Q_CHK  = 12'b0001_0000_0000,
        S_Q_UP   = 12'b0010_0000_0000,
        S_Q_SIB  = 12'b0100_0000_0000,
        S_FIN    = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_query) begin
                    n_state = i_sts.in_range ? S_Q_LEAF : S_FIN;
                end else begin
                    n_state = i_sts.in_range ? S_W_RD : S_IDLE;
                end
            end
            S_W_RD: begin
                o_cmd.str_rw = 1'b1;
                n_state      = S_W_LEAF;
            end
            S_W_LEAF: begin
                o_cmd.leaf_set = 1'b1;
                n_state        = S_W_UP;
            end
            S_W_UP: begin
                if (i_sts.root) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.sib_rd = 1'b1;
                    n_state      = S_W_PAR;
                end
            end
            S_W_PAR: begin
                o_cmd.par_write = 1'b1;
                n_state         = S_W_UP;
            end
            S_Q_LEAF: begin
                o_cmd.leaf_rd = 1'b1;
                n_state       = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (i_sts.leaf_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.acc_one = 1'b1;
                    n_state       = S_Q_UP;
                end
            end
            S_Q_UP: begin
                if (i_sts.root) begin
                    n_state = S_FIN;
                end else if (i_sts.node_right) begin
                    // right child: the parent ends where this node ends
                    o_cmd.climb = 1'b1;
                end else begin
                    o_cmd.sib_rd = 1'b1;
                    n_state      = S_Q_SIB;
                end
            end
            S_Q_SIB: begin
                o_cmd.acc_sib = 1'b1;
                if (i_sts.sib_full) begin
                    o_cmd.climb = 1'b1;
                    n_state     = S_Q_UP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/mrlt_dp.sv
// string memories, leading-run tree memory, walk registers and result register
module mrlt_dp #(
    parameter int MAX_LEN = mrlt_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [mrlt_pkg::LEN_W-1:0]    i_cfg_data,
    input  logic [mrlt_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [mrlt_pkg::S_USER_W-1:0] i_s_tuser,
    input  mrlt_pkg::t_cmd                i_cmd,
    output mrlt_pkg::t_sts                o_sts,
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic [mrlt_pkg::M_DATA_W-1:0] o_m_tdata
);
    import mrlt_pkg::*;

    localparam int LG   = $clog2(MAX_LEN);
    localparam int P    = 1 << LG;
    localparam int NW   = LG + 1;
    localparam int CW   = LG + 1;
    localparam int LW   = (LEN_W > CW) ? LEN_W : CW;
    localparam int LRST = (LEN_RESET > MAX_LEN) ? MAX_LEN : LEN_RESET;

    // memories
    logic [CHAR_W-1:0] mem_a    [MAX_LEN];
    logic [CHAR_W-1:0] mem_b    [MAX_LEN];
    logic [CW-1:0]     mem_tree [2*P];

    // control registers
    logic [LW-1:0]  r_len_eff;
    logic [NW-1:0]  r_clr_cnt;
    logic [CW-1:0]  r_clr_span;
    logic           r_out_valid;

    // payload registers
    logic              r_mode;
    logic              r_which;
    logic [POS_W-1:0]  r_pos;
    logic [CHAR_W-1:0] r_char;
    logic [NW-1:0]     r_node;
    logic [CW-1:0]     r_span;
    logic [CW-1:0]     r_cur;
    logic [CW-1:0]     r_acc;
    logic [CHAR_W-1:0] r_rd_a;
    logic [CHAR_W-1:0] r_rd_b;
    logic [CW-1:0]     r_tree_rd;
    logic [RUN_W-1:0]  r_out;

    // next values and combinational terms
    logic [LW-1:0]     n_len_eff;
    logic [LW-1:0]     cfg_x;
    logic [NW-1:0]     n_clr_cnt;
    logic [CW-1:0]     n_clr_span;
    logic              clr_str_ok;
    logic [LW-1:0]     pos_x;
    logic [LG-1:0]     pos_idx;
    logic [NW-1:0]     leaf_idx;
    logic [NW-1:0]     sib_idx;
    logic              in_range;
    logic [CHAR_W-1:0] other_rd;
    logic              match;
    logic [CW-1:0]     lval;
    logic [CW-1:0]     rval;
    logic [CW-1:0]     par_val;
    logic [LW-1:0]     rem;
    logic [LW-1:0]     acc_x;
    logic [LW-1:0]     res;

    logic              a_we;
    logic              b_we;
    logic [LG-1:0]     s_waddr;
    logic [CHAR_W-1:0] s_wdata;
    logic              t_we;
    logic [NW-1:0]     t_waddr;
    logic [CW-1:0]     t_wdata;
    logic [NW-1:0]     t_raddr;

    // length clamp at the configured depth
    assign cfg_x     = LW'(i_cfg_data);
    assign n_len_eff = (cfg_x > LW'(MAX_LEN)) ? LW'(MAX_LEN) : cfg_x;

    // clearing sweep: node spans halve at each power of two
    assign n_clr_cnt  = r_clr_cnt + NW'(1);
    assign n_clr_span = ((n_clr_cnt & r_clr_cnt) == '0) ? (r_clr_span >> 1) : r_clr_span;
    assign clr_str_ok = {1'b0, r_clr_cnt[LG-1:0]} < NW'(MAX_LEN);

    // position decode
    assign pos_x    = LW'(r_pos);
    assign pos_idx  = pos_x[LG-1:0];
    assign leaf_idx = {1'b1, pos_idx};
    assign sib_idx  = r_node ^ NW'(1);
    assign in_range = pos_x < r_len_eff;

    // leaf match against the other string
    assign other_rd = r_which ? r_rd_a : r_rd_b;
    assign match    = (other_rd == r_char);

    // merge of two children into the parent leading run
    assign lval    = r_node[0] ? r_tree_rd : r_cur;
    assign rval    = r_node[0] ? r_cur : r_tree_rd;
    assign par_val = (lval == r_span) ? (r_span + rval) : lval;

    // final run clipped to the in-use length
    assign rem   = r_len_eff - pos_x;
    assign acc_x = LW'(r_acc);
    assign res   = (acc_x < rem) ? acc_x : rem;

    // string write port select
    always_comb begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        s_waddr = pos_idx;
        s_wdata = r_char;
        if (i_cmd.clr) begin
            a_we    = clr_str_ok;
            b_we    = clr_str_ok;
            s_waddr = r_clr_cnt[LG-1:0];
            s_wdata = '0;
        end else if (i_cmd.str_rw) begin
            a_we = !r_which;
            b_we = r_which;
        end
    end

    // tree write and read port select
    always_comb begin
        t_we    = 1'b0;
        t_waddr = r_node >> 1;
        t_wdata = par_val;
        if (i_cmd.clr) begin
            t_we    = 1'b1;
            t_waddr = r_clr_cnt;
            t_wdata = r_clr_span;
        end else if (i_cmd.leaf_set) begin
            t_we    = 1'b1;
            t_waddr = leaf_idx;
            t_wdata = CW'(match);
        end else if (i_cmd.par_write) begin
            t_we = 1'b1;
        end
    end

    assign t_raddr = i_cmd.leaf_rd ? leaf_idx : sib_idx;

    // string memories
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            mem_a[s_waddr] <= s_wdata;
        end
        if (b_we) begin
            mem_b[s_waddr] <= s_wdata;
        end
        if (i_cmd.str_rw) begin
            r_rd_a <= mem_a[pos_idx];
            r_rd_b <= mem_b[pos_idx];
        end
    end

    // tree memory
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            mem_tree[t_waddr] <= t_wdata;
        end
        if (i_cmd.leaf_rd || i_cmd.sib_rd) begin
            r_tree_rd <= mem_tree[t_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_eff   <= LW'(LRST);
            r_clr_cnt   <= NW'(1);
            r_clr_span  <= CW'(P);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len_eff <= n_len_eff;
            end
            if (i_cmd.clr) begin
                r_clr_cnt  <= n_clr_cnt;
                r_clr_span <= n_clr_span;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input capture and tree walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_s_tuser[MODE_BIT];
            r_which <= i_s_tuser[SEL_BIT];
            r_pos   <= i_s_tdata[POS_LSB +: POS_W];
            r_char  <= i_s_tdata[CHAR_LSB +: CHAR_W];
            r_acc   <= '0;
        end
        if (i_cmd.leaf_set) begin
            r_node <= leaf_idx;
            r_span <= CW'(1);
            r_cur  <= CW'(match);
        end
        if (i_cmd.leaf_rd) begin
            r_node <= leaf_idx;
            r_span <= CW'(1);
        end
        if (i_cmd.par_write) begin
            r_cur  <= par_val;
            r_node <= r_node >> 1;
            r_span <= r_span << 1;
        end
        if (i_cmd.climb) begin
            r_node <= r_node >> 1;
            r_span <= r_span << 1;
        end
        if (i_cmd.acc_one) begin
            r_acc <= CW'(1);
        end
        if (i_cmd.acc_sib) begin
            r_acc <= r_acc + r_tree_rd;
        end
        if (i_cmd.out_load) begin
            r_out <= in_range ? RUN_W'(res) : '0;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.clear_last = (r_clr_cnt == '1);
        o_sts.is_query   = (r_mode == MODE_QUERY);
        o_sts.in_range   = in_range;
        o_sts.root       = (r_node == NW'(1));
        o_sts.node_right = r_node[0];
        o_sts.leaf_zero  = (r_tree_rd == '0);
        o_sts.sib_full   = (r_tree_rd == r_span);
        o_sts.out_free   = !r_out_valid || i_m_ready;
    end

    assign o_m_valid = r_out_valid;
    assign o_m_tdata = M_DATA_W'(r_out);

endmodule

// File: sv/matching_run_length_tracker.sv
// Top level: matching run-length tracker over two byte strings and a leading-run tree.
// A write word passes decode, the string write and read, the leaf update and one merge per tree level
// before the next word is accepted. A query climbs from its leaf, adding sibling runs; its result is
// loaded when the result register is free (a result still waiting holds this off), the next word in the cycle after.
// Synchronous active-low reset; afterwards a clearing pass zeroes both strings and loads the tree,
// with s_axis_tready low; config writes are taken always.
module matching_run_length_tracker #(
    parameter int MAX_LEN = mrlt_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // length register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mrlt_pkg::LEN_W-1:0]    i_cfg_data,     // string_length
    // input words
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [mrlt_pkg::S_DATA_W-1:0] i_s_axis_tdata,  // position[9:0], char_value[17:10]
    input  logic [mrlt_pkg::S_USER_W-1:0] i_s_axis_tuser,  // mode[0], which_string[1]
    // result words
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [mrlt_pkg::M_DATA_W-1:0] o_m_axis_tdata   // run_length[10:0]
);
    import mrlt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // the user must issue register writes only while idle; the block itself does not enforce it
    assign o_cfg_ready = 1'b1;

    // sequencer
    mrlt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // storage and arithmetic
    mrlt_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata)
    );

    // an accepted word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken again right after acceptance");

    // a result is never loaded over one that is still waiting
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register overwritten");

    // the parent merge never runs at the root
    a_merge_below_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.par_write |-> !sts.root)
        else $error("parent merge issued at the root");

    // no input is taken during the clearing sweep
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr |-> !o_s_axis_tready)
        else $error("input ready during clearing pass");

endmodule
